// ===== rtl/shs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
        logic       msg_phase;
    } sched_ctl_t;

    typedef struct packed {
        logic       load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       fold;
        logic       reinit;
    } rnd_ctl_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [6:0] ROUNDS    = 7'd64;
    localparam logic [6:0] MSG_WORDS = 7'd16;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/shs_msg_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_msg_sched
// 512-bit block shift line: collects bytes, then rolls as the 16-word
// message schedule, one word per step into a registered w.
// ----------------------------------------------------------------------------
module shs_msg_sched
    import shs_pkg::*;
(
    input  logic        clk,
    input  sched_ctl_t  ctl,
    output logic [31:0] w
);

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  w_reg;
    logic [31:0]  w_next;
    logic [31:0]  w_new;

    // word 0 is the oldest (w[t-16]), word 15 the newest
    always_comb
    begin
        if (ctl.msg_phase)
        begin
            w_new = blk_reg[511:480];
        end
        else
        begin
            w_new = blk_reg[511:480] + small_sigma0(blk_reg[479:448])
                  + blk_reg[223:192] + small_sigma1(blk_reg[63:32]);
        end
    end

    always_comb
    begin
        blk_next = blk_reg;
        w_next   = w_reg;
        if (ctl.push)
        begin
            blk_next = {blk_reg[503:0], ctl.push_byte};
        end
        else if (ctl.step)
        begin
            blk_next = {blk_reg[479:0], w_new};
            w_next   = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        w_reg   <= w_next;
    end

    assign w = w_reg;

endmodule

// ===== rtl/shs_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_round
// Chaining words and working variables with one shared SHA-256 round unit.
// ----------------------------------------------------------------------------
module shs_round
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rnd_ctl_t     ctl,
    input  logic [31:0]  w,
    output logic [255:0] digest
);

    logic [31:0] chain_reg [8];
    logic [31:0] vars_reg  [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb
    begin
        ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
            ^ (vars_reg[1] & vars_reg[2]);
        t1  = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + round_k(ctl.round_idx) + w;
        t2  = big_sigma0(vars_reg[0]) + maj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                vars_reg[i] <= chain_reg[i];
            end
        end
        else if (ctl.round_en)
        begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV_WORDS[i];
            end
        end
        else if (ctl.reinit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV_WORDS[i];
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
        end
    end

    assign digest = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                     chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};

endmodule

// ===== rtl/shs_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_out_buf
// Digest holding register; drains the digest as four 64-bit items.
// ----------------------------------------------------------------------------
module shs_out_buf
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic [255:0] digest,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [63:0]  digest_word,
    output logic [1:0]   word_index,
    output logic         last_word,
    output logic         busy
);

    logic [255:0] buf_reg;
    logic [255:0] buf_next;
    logic         valid_reg;
    logic         valid_next;
    logic [1:0]   idx_reg;
    logic [1:0]   idx_next;
    logic         take;

    assign take = valid_reg && out_ready;

    always_comb
    begin
        buf_next   = buf_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            buf_next   = digest;
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            buf_next = {buf_reg[191:0], 64'h0};
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_valid   = valid_reg;
    assign digest_word = buf_reg[255:192];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);
    assign busy        = valid_reg;

endmodule

// ===== rtl/shs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: byte intake, round counting, padding byte by byte, digest hand-off.
// ----------------------------------------------------------------------------
module shs_ctrl
    import shs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       carries_byte,
    input  logic       last_of_message,
    output logic       in_ready,
    input  logic       ob_busy,
    output logic       ob_load,
    output sched_ctl_t sched,
    output rnd_ctl_t   rnd
);

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [63:0] byte_total_reg;
    logic [63:0] byte_total_next;
    logic        pad_reg;
    logic        pad_next;
    logic        mark_reg;
    logic        mark_next;
    logic        extra_reg;
    logic        extra_next;
    logic        final_reg;
    logic        final_next;

    logic        accept;
    logic        len_phase;
    logic [63:0] bit_len;
    logic [5:0]  len_base;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign len_phase = mark_reg && (fill_reg >= LEN_START) && !extra_reg;
    assign bit_len   = {byte_total_reg[60:0], 3'b000};
    // big-endian length: slot 56 gets bits 63..56
    assign len_base  = {~fill_reg[2:0], 3'b111};
    assign len_byte  = bit_len[len_base -: 8];
    assign pad_byte  = !mark_reg ? PAD_MARK : (len_phase ? len_byte : 8'h00);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (carries_byte && (fill_reg == FILL_LAST))
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (last_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == ROUNDS)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (final_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_DONE:
            begin
                if (!ob_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next       = fill_reg;
        byte_total_next = byte_total_reg;
        pad_next        = pad_reg;
        mark_next       = mark_reg;
        extra_next      = extra_reg;
        final_next      = final_reg;
        cnt_next        = (state_reg == ST_ROUND) ? cnt_reg + 7'd1 : 7'd0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (carries_byte)
                    begin
                        fill_next       = fill_reg + 6'd1;
                        byte_total_next = byte_total_reg + 64'd1;
                    end
                    if (last_of_message)
                    begin
                        pad_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next  = 1'b1;
                    extra_next = (fill_reg >= LEN_START);
                end
                if (fill_reg == FILL_LAST)
                begin
                    extra_next = 1'b0;
                    if (len_phase)
                    begin
                        final_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ob_busy)
                begin
                    fill_next       = 6'd0;
                    byte_total_next = 64'd0;
                    pad_next        = 1'b0;
                    mark_next       = 1'b0;
                    extra_next      = 1'b0;
                    final_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        sched.push      = (accept && carries_byte) || (state_reg == ST_PAD);
        sched.push_byte = (state_reg == ST_PAD) ? pad_byte : data_byte;
        sched.step      = (state_reg == ST_ROUND) && (cnt_reg < ROUNDS);
        sched.msg_phase = (cnt_reg < MSG_WORDS);
        rnd.load        = (state_reg == ST_ROUND) && (cnt_reg == 7'd0);
        rnd.round_en    = (state_reg == ST_ROUND) && (cnt_reg != 7'd0);
        rnd.round_idx   = 6'(cnt_reg - 7'd1);
        rnd.fold        = (state_reg == ST_FOLD);
        rnd.reinit      = (state_reg == ST_DONE) && !ob_busy;
        ob_load         = (state_reg == ST_DONE) && !ob_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 6'd0;
            cnt_reg        <= 7'd0;
            byte_total_reg <= 64'd0;
            pad_reg        <= 1'b0;
            mark_reg       <= 1'b0;
            extra_reg      <= 1'b0;
            final_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            byte_total_reg <= byte_total_next;
            pad_reg        <= pad_next;
            mark_reg       <= mark_next;
            extra_reg      <= extra_next;
            final_reg      <= final_next;
        end
    end

    a_load_round_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rnd.load && rnd.round_en))
        else $error("vars load and round update together");

    a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (cnt_reg == ROUNDS) |=> (state_reg == ST_FOLD))
        else $error("fold did not follow the last round");

    a_final_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(final_reg) |-> (fill_reg == 6'd0) && (state_reg == ST_ROUND))
        else $error("final padded block not aligned");

    a_new_message_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !ob_busy |=> (byte_total_reg == 64'd0) && !pad_reg)
        else $error("message state not cleared after digest");

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest out as four 64-bit big-endian words.
// ----------------------------------------------------------------------------
// An item that only carries a byte leaves in_ready high for the next item.
// The item that completes a 64-byte block starts a compression (schedule
// preload, 64 rounds on the single shared round unit, chain fold) during
// which in_ready is low. An item with the last mark then feeds padding
// through the block shift line at one byte per cycle (0x80, zeros, 8 length
// bytes) up to the end of each padding block, with one or two compressions,
// and the done state then hands the digest to the output buffer. The buffer
// lets a new message start while the four digest items drain; a second
// digest waits for the buffer to empty.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        carries_byte,
    input  logic        last_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    sched_ctl_t   sched_ctl;
    rnd_ctl_t     rnd_ctl;
    logic [31:0]  sched_w;
    logic [255:0] digest;
    logic         ob_busy;
    logic         ob_load;

    shs_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .data_byte       (data_byte),
        .carries_byte    (carries_byte),
        .last_of_message (last_of_message),
        .in_ready        (in_ready),
        .ob_busy         (ob_busy),
        .ob_load         (ob_load),
        .sched           (sched_ctl),
        .rnd             (rnd_ctl)
    );

    shs_msg_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w   (sched_w)
    );

    shs_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rnd_ctl),
        .w      (sched_w),
        .digest (digest)
    );

    shs_out_buf u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ob_load),
        .digest      (digest),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .busy        (ob_busy)
    );

endmodule

// ===== test/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the stream hasher. It keeps its own SHA-256
// state, works out the four digest words that each ending item produces,
// and compares every accepted output item against the oldest pending word.
// ----------------------------------------------------------------------------
module sha256_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        carries_byte,
    input  logic        last_of_message,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] digest_word,
    input  logic [1:0]  word_index,
    input  logic        last_word,
    output int          mismatches,
    output int          words_pending
);

    typedef struct {
        logic [63:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int         LEN_POS  = 56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    int           fill;
    logic [63:0]  byte_total;
    digest_beat_t digest_q [$];
    int           err_total;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    task automatic restart_message();
        int i;
        for (i = 0; i < 8; i++)
            chain[i] = H_INIT[i];
        fill = 0;
        byte_total = '0;
    endtask

    task automatic compress_into_chain();
        logic [31:0] w [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (r = 16; r < 64; r++)
            w[r] = w[r-16] + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                 + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
        va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
        ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
        for (r = 0; r < 64; r++)
        begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
               + ((ve & vf) ^ (~ve & vg)) + KTAB[r] + w[r];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
               + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
        chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic has_byte,
                               input logic ends_msg);
        logic [63:0]  bit_len;
        digest_beat_t beat;
        int i;
        if (has_byte)
        begin
            blk[fill] = b;
            fill = fill + 1;
            byte_total = byte_total + 64'd1;
            if (fill == 64)
            begin
                compress_into_chain();
                fill = 0;
            end
        end
        if (ends_msg)
        begin
            bit_len = byte_total << 3;
            blk[fill] = PAD_BYTE;
            fill = fill + 1;
            // no room for the length: spill into an extra block
            if (fill > LEN_POS)
            begin
                for (i = fill; i < 64; i++)
                    blk[i] = 8'h00;
                compress_into_chain();
                fill = 0;
            end
            for (i = fill; i < LEN_POS; i++)
                blk[i] = 8'h00;
            for (i = 0; i < 8; i++)
                blk[LEN_POS + i] = bit_len[63 - 8*i -: 8];
            compress_into_chain();
            for (i = 0; i < 4; i++)
            begin
                beat.word = {chain[2*i], chain[2*i+1]};
                beat.idx  = 2'(i);
                beat.last = (i == 3);
                digest_q  = {digest_q, beat};
            end
            restart_message();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t head;
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
            err_total = 0;
            mismatches <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual %h idx %0d last %b",
                             $time, digest_word, word_index, last_word);
                    err_total++;
                end
                else
                begin
                    head = digest_q.pop_front();
                    if (digest_word !== head.word)
                    begin
                        $display("%0t: digest_word: expected %h, actual %h",
                                 $time, head.word, digest_word);
                        err_total++;
                    end
                    if (word_index !== head.idx)
                    begin
                        $display("%0t: word_index: expected %0d, actual %0d",
                                 $time, head.idx, word_index);
                        err_total++;
                    end
                    if (last_word !== head.last)
                    begin
                        $display("%0t: last_word: expected %b, actual %b",
                                 $time, head.last, last_word);
                        err_total++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_item(data_byte, carries_byte, last_of_message);
            mismatches <= err_total;
            words_pending <= digest_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the SHA-256 stream hasher. Directed messages
// cover the empty message, ignored bytes, bytes that carry the end mark and
// padding boundaries; random messages of mostly short length follow under
// three idling regimes, with one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEMS       = 260;
    localparam int HOLD_CYCLES = 1000;
    localparam int TAIL_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte       = 8'h00;
    logic        carries_byte    = 1'b0;
    logic        last_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    int   mismatches;
    int   words_pending;
    int   send_idle_pct = 15;
    int   recv_idle_pct = 54;
    logic hold_trig     = 1'b0;
    logic hold_taken    = 1'b0;
    int   hold_left     = 0;
    int   cycle_count   = 0;

    always #5 clk = ~clk;

    sha256_stream_hasher dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .carries_byte    (carries_byte),
        .last_of_message (last_of_message),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .digest_word     (digest_word),
        .word_index      (word_index),
        .last_word       (last_word)
    );

    sha256_digest_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .carries_byte    (carries_byte),
        .last_of_message (last_of_message),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .digest_word     (digest_word),
        .word_index      (word_index),
        .last_word       (last_word),
        .mismatches      (mismatches),
        .words_pending   (words_pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_trig && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [7:0] b, input logic has_byte, input logic ends_msg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        carries_byte <= has_byte;
        last_of_message <= ends_msg;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_digests();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
    endtask

    initial
    begin
        int   fed;
        int   msg_n;
        int   len;
        int   k;
        int   phase;
        int   pick;
        logic tie;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        fed = 0;
        msg_n = 0;
        phase = 0;
        while (fed < ITEMS)
        begin
            if (phase == 0 && fed >= ITEMS / 3)
            begin
                drain_digests();
                send_idle_pct = 54;
                recv_idle_pct <= 15;
                phase = 1;
            end
            else if (phase == 1 && fed >= 2 * ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                hold_trig <= 1'b1;
                phase = 2;
            end
            // padding boundaries first, then mostly short messages
            case (msg_n)
                0: begin len = 64; tie = 1'b1; end
                1: begin len = 56; tie = 1'b0; end
                2: begin len = 55; tie = 1'b1; end
                3: begin len = 63; tie = 1'b0; end
                default:
                begin
                    pick = $urandom_range(99);
                    if (pick < 60)
                        len = $urandom_range(12);
                    else if (pick < 85)
                        len = $urandom_range(65, 51);
                    else
                        len = $urandom_range(50, 13);
                    tie = 1'($urandom_range(1));
                end
            endcase
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 8)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                send_item(8'($urandom_range(255)), 1'b1, tie && (k == len - 1));
                fed++;
            end
            if (!tie || len == 0)
            begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
                fed++;
            end
            msg_n++;
        end
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);

        drain_digests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
